### hdl/mtbdc_pkg.sv
// shared types, constants and codes of the timer bank
package mtbdc_pkg;

  localparam int NUM_TIMERS_DEF = 8;

  localparam int OP_W     = 2;
  localparam int ID_W     = 3;
  localparam int MS_W     = 32;
  localparam int TICK_W   = 16;
  localparam int CNT_W    = 17;
  localparam int DRIFT_W  = 32;
  localparam int DVD_W    = 21;
  localparam int DVS_W    = 16;
  localparam int PROD_W   = 22;
  localparam int IN_DW    = 56;
  localparam int OUT_DW   = 24;

  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  localparam logic [MS_W-1:0]    TIME_CAP_IN  = 32'h0012_FFED;
  localparam logic [DVD_W-1:0]   TIME_CAP_OUT = 21'h00_FFFF;
  localparam logic [DVD_W-1:0]   MIN_DIV_MS   = 21'd100;
  localparam logic [DVS_W-1:0]   TICK_MS      = 16'd50;
  localparam logic [DRIFT_W-1:0] DRIFT_STEP   = 32'd50;

  typedef struct packed {
    logic [TICK_W-1:0]  rem;
    logic [TICK_W-1:0]  per;
    logic [DRIFT_W-1:0] drift;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic load;
    logic stop_clr;
    logic set_one;
    logic div_ms;
    logic expire;
    logic dec;
    logic post_ms;
    logic post_over;
    logic acc;
    logic wr;
    logic emit;
    logic next;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            id_ok;
    logic            rem_zero;
    logic            rem_gt_el;
    logic            t_ge_min;
    logic            need_div;
    logic            div_busy;
    logic            exp;
    logic            idx_last;
    logic            out_free;
    logic            pend_valid;
  } sts_t;

endpackage

### hdl/multi_timer_bank_drift_comp_unit.sv
// top level of the drift-compensated timer bank
// A start or stop item goes through the divider only when the delay needs the divide by 50.
// A tick item walks every timer in turn through one read port of the timer store;
// an expiring timer that has overrun by a period or more uses the shared 21-bit
// iterative divider. Expiries come out in ascending timer order, the last one of
// a tick item marked with out_tlast; one result is held back until the next is
// known, so the block may wait on out_tready.
module multi_timer_bank_drift_comp_unit #(
  parameter int NUM_TIMERS = mtbdc_pkg::NUM_TIMERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // opcode, timer_id, start_time_ms, elapsed_ticks
  input  logic [mtbdc_pkg::IN_DW-1:0]   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // expired_id, periods_elapsed
  output logic [mtbdc_pkg::OUT_DW-1:0]  out_tdata,
  output logic                          out_tlast
);

  mtbdc_pkg::cmd_t cmd;
  mtbdc_pkg::sts_t sts;

  mtbdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mtbdc_datapath #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_ms || cmd.expire) |-> !sts.div_busy)
    else $error("divider started while busy");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !sts.pend_valid)
    else $error("held result left behind after item");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.flush) |-> (sts.out_free || !sts.pend_valid))
    else $error("result pushed over a waiting result");

endmodule

### hdl/mtbdc_divider.sv
// iterative restoring divider, one quotient bit per cycle
module mtbdc_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [mtbdc_pkg::DVD_W-1:0]    dividend,
  input  logic [mtbdc_pkg::DVS_W-1:0]    divisor,
  output logic                           busy,
  output logic [mtbdc_pkg::DVD_W-1:0]    quotient,
  output logic [mtbdc_pkg::DVS_W-1:0]    remainder
);

  localparam int CW = $clog2(mtbdc_pkg::DVD_W + 1);

  logic [CW-1:0]                  cnt_r;
  logic                           busy_r;
  logic [mtbdc_pkg::DVD_W-1:0]    q_r;
  logic [mtbdc_pkg::DVS_W-1:0]    acc_r;
  logic [mtbdc_pkg::DVS_W-1:0]    dvs_r;
  logic [mtbdc_pkg::DVS_W:0]      trial;
  logic                           fits;

  assign trial = {acc_r, q_r[mtbdc_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(mtbdc_pkg::DVD_W);
      q_r    <= dividend;
      acc_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
      if (fits) begin
        acc_r <= mtbdc_pkg::DVS_W'(trial - {1'b0, dvs_r});
      end else begin
        acc_r <= trial[mtbdc_pkg::DVS_W-1:0];
      end
      q_r <= {q_r[mtbdc_pkg::DVD_W-2:0], fits};
    end
  end

  assign busy      = busy_r;
  assign quotient  = q_r;
  assign remainder = acc_r;

endmodule

### hdl/mtbdc_datapath.sv
// timer storage, working registers, divider and result registers
module mtbdc_datapath #(
  parameter int NUM_TIMERS = mtbdc_pkg::NUM_TIMERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mtbdc_pkg::cmd_t               cmd,
  output mtbdc_pkg::sts_t               sts,
  input  logic [mtbdc_pkg::IN_DW-1:0]   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mtbdc_pkg::OUT_DW-1:0]  out_tdata,
  output logic                          out_tlast
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  mtbdc_pkg::entry_t mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] vld_r;

  logic [mtbdc_pkg::OP_W-1:0]    op_r;
  logic [mtbdc_pkg::ID_W-1:0]    id_r;
  logic [mtbdc_pkg::MS_W-1:0]    ms_r;
  logic [mtbdc_pkg::TICK_W-1:0]  el_r;
  logic [IDX_W-1:0]              idx_r;
  mtbdc_pkg::entry_t             rd_q_r;
  logic                          rd_v_r;
  logic [mtbdc_pkg::TICK_W-1:0]  w_rem_r;
  logic [mtbdc_pkg::TICK_W-1:0]  w_per_r;
  logic [mtbdc_pkg::DRIFT_W-1:0] w_drift_r;
  logic [mtbdc_pkg::CNT_W-1:0]   cnt_r;
  logic [mtbdc_pkg::PROD_W-1:0]  prod_r;
  logic                          exp_r;
  logic                          pend_v_r;
  logic [mtbdc_pkg::ID_W-1:0]    pend_id_r;
  logic [mtbdc_pkg::CNT_W-1:0]   pend_cnt_r;
  logic                          out_v_r;
  logic [mtbdc_pkg::ID_W-1:0]    out_id_r;
  logic [mtbdc_pkg::CNT_W-1:0]   out_cnt_r;
  logic                          out_last_r;

  logic [IDX_W-1:0]              addr;
  mtbdc_pkg::entry_t             ent;
  mtbdc_pkg::entry_t             wr_ent;
  logic [mtbdc_pkg::DVD_W-1:0]   t_cap;
  logic                          ge50;
  logic [mtbdc_pkg::CNT_W-1:0]   over_adj;
  logic                          need_div;
  logic                          div_start;
  logic [mtbdc_pkg::DVD_W-1:0]   div_dvd;
  logic [mtbdc_pkg::DVS_W-1:0]   div_dvs;
  logic                          div_busy;
  logic [mtbdc_pkg::DVD_W-1:0]   quo;
  logic [mtbdc_pkg::DVS_W-1:0]   rmd;
  logic [mtbdc_pkg::TICK_W-1:0]  q16;
  logic                          out_free;

  assign addr   = (op_r == mtbdc_pkg::OP_TICK) ? idx_r : IDX_W'(id_r);
  assign ent    = rd_v_r ? rd_q_r : '0;
  assign wr_ent = '{rem: w_rem_r, per: w_per_r, drift: w_drift_r};

  assign t_cap = (ms_r > mtbdc_pkg::TIME_CAP_IN) ? mtbdc_pkg::TIME_CAP_OUT
                                                 : ms_r[mtbdc_pkg::DVD_W-1:0];
  assign ge50     = w_drift_r >= mtbdc_pkg::DRIFT_STEP;
  assign over_adj = mtbdc_pkg::CNT_W'(el_r) - mtbdc_pkg::CNT_W'(w_rem_r)
                    + mtbdc_pkg::CNT_W'(ge50);
  assign need_div = (w_per_r != '0) && (over_adj >= mtbdc_pkg::CNT_W'(w_per_r));

  assign div_start = cmd.div_ms || (cmd.expire && need_div);
  assign div_dvd   = cmd.div_ms ? t_cap : mtbdc_pkg::DVD_W'(over_adj);
  assign div_dvs   = cmd.div_ms ? mtbdc_pkg::TICK_MS : w_per_r;
  assign q16       = quo[mtbdc_pkg::TICK_W-1:0];
  assign out_free  = !out_v_r || out_tready;

  mtbdc_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .quotient  (quo),
    .remainder (rmd)
  );

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wr_ent;
    end
    if (cmd.rd) begin
      rd_q_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      exp_r    <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      idx_r    <= '0;
      op_r     <= '0;
    end else begin
      if ((cmd.emit && pend_v_r) || cmd.flush) begin
        out_v_r <= 1'b1;
      end else if (out_v_r && out_tready) begin
        out_v_r <= 1'b0;
      end
      if (cmd.accept) begin
        op_r  <= in_tdata[1:0];
        id_r  <= in_tdata[4:2];
        ms_r  <= in_tdata[36:5];
        el_r  <= in_tdata[52:37];
        idx_r <= '0;
      end
      if (cmd.rd) begin
        rd_v_r <= vld_r[addr];
      end
      if (cmd.load) begin
        w_rem_r   <= ent.rem;
        w_per_r   <= ent.per;
        w_drift_r <= ent.drift;
        exp_r     <= 1'b0;
      end
      if (cmd.stop_clr) begin
        w_rem_r <= '0;
        w_per_r <= '0;
      end
      if (cmd.set_one) begin
        w_rem_r <= mtbdc_pkg::TICK_W'(1);
        w_per_r <= mtbdc_pkg::TICK_W'(1);
      end
      if (cmd.dec) begin
        w_rem_r <= w_rem_r - el_r;
      end
      if (cmd.expire) begin
        w_rem_r <= '0;
        w_per_r <= '0;
        exp_r   <= 1'b1;
        cnt_r   <= mtbdc_pkg::CNT_W'(1);
        if (ge50) begin
          w_drift_r <= w_drift_r - mtbdc_pkg::DRIFT_STEP;
        end
      end
      if (cmd.post_ms) begin
        w_per_r <= q16;
        if (q16 > mtbdc_pkg::TICK_W'(1) && ge50) begin
          w_rem_r   <= q16 - mtbdc_pkg::TICK_W'(1);
          w_drift_r <= w_drift_r - mtbdc_pkg::DRIFT_STEP;
        end else begin
          w_rem_r <= q16;
        end
      end
      if (cmd.post_over) begin
        cnt_r  <= quo[mtbdc_pkg::CNT_W-1:0] + mtbdc_pkg::CNT_W'(1);
        prod_r <= mtbdc_pkg::PROD_W'(rmd) * mtbdc_pkg::PROD_W'(mtbdc_pkg::TICK_MS);
      end
      if (cmd.acc) begin
        w_drift_r <= w_drift_r + mtbdc_pkg::DRIFT_W'(prod_r);
      end
      if (cmd.wr) begin
        vld_r[addr] <= 1'b1;
      end
      if (cmd.emit) begin
        if (pend_v_r) begin
          out_id_r   <= pend_id_r;
          out_cnt_r  <= pend_cnt_r;
          out_last_r <= 1'b0;
        end
        pend_v_r   <= 1'b1;
        pend_id_r  <= mtbdc_pkg::ID_W'(idx_r);
        pend_cnt_r <= cnt_r;
      end
      if (cmd.flush) begin
        out_id_r   <= pend_id_r;
        out_cnt_r  <= pend_cnt_r;
        out_last_r <= 1'b1;
        pend_v_r   <= 1'b0;
      end
      if (cmd.next) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  assign sts.op         = op_r;
  assign sts.id_ok      = 32'(id_r) < 32'(NUM_TIMERS);
  assign sts.rem_zero   = w_rem_r == '0;
  assign sts.rem_gt_el  = w_rem_r > el_r;
  assign sts.t_ge_min   = t_cap >= mtbdc_pkg::MIN_DIV_MS;
  assign sts.need_div   = need_div;
  assign sts.div_busy   = div_busy;
  assign sts.exp        = exp_r;
  assign sts.idx_last   = idx_r == IDX_W'(NUM_TIMERS - 1);
  assign sts.out_free   = out_free;
  assign sts.pend_valid = pend_v_r;

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_cnt_r, out_id_r};
  assign out_tlast  = out_last_r;

endmodule

### hdl/mtbdc_ctrl.sv
// sequencer for start, stop and tick items
module mtbdc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  mtbdc_pkg::sts_t sts,
  output mtbdc_pkg::cmd_t cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DEC   = 4'd1;
  localparam logic [3:0] ST_RD    = 4'd2;
  localparam logic [3:0] ST_LOAD  = 4'd3;
  localparam logic [3:0] ST_EVAL  = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_POST  = 4'd6;
  localparam logic [3:0] ST_ACC   = 4'd7;
  localparam logic [3:0] ST_WR    = 4'd8;
  localparam logic [3:0] ST_EMIT  = 4'd9;
  localparam logic [3:0] ST_NEXT  = 4'd10;
  localparam logic [3:0] ST_FLUSH = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       is_tick;

  assign is_tick   = sts.op == mtbdc_pkg::OP_TICK;
  assign in_tready = state_r == ST_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DEC;
        end
      end
      ST_DEC: begin
        if (is_tick || ((sts.op == mtbdc_pkg::OP_START || sts.op == mtbdc_pkg::OP_STOP)
                        && sts.id_ok)) begin
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.op == mtbdc_pkg::OP_STOP) begin
          cmd.stop_clr = 1'b1;
          state_nxt    = ST_WR;
        end else if (!is_tick) begin
          if (sts.t_ge_min) begin
            cmd.div_ms = 1'b1;
            state_nxt  = ST_DIV;
          end else begin
            cmd.set_one = 1'b1;
            state_nxt   = ST_WR;
          end
        end else if (sts.rem_zero) begin
          state_nxt = ST_NEXT;
        end else if (sts.rem_gt_el) begin
          cmd.dec   = 1'b1;
          state_nxt = ST_WR;
        end else begin
          cmd.expire = 1'b1;
          state_nxt  = sts.need_div ? ST_DIV : ST_WR;
        end
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (is_tick) begin
          cmd.post_over = 1'b1;
          state_nxt     = ST_ACC;
        end else begin
          cmd.post_ms = 1'b1;
          state_nxt   = ST_WR;
        end
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        cmd.wr = 1'b1;
        if (!is_tick) begin
          state_nxt = ST_IDLE;
        end else if (sts.exp) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_EMIT: begin
        if (!sts.pend_valid || sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (sts.idx_last) begin
          state_nxt = ST_FLUSH;
        end else begin
          cmd.next  = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sim/tb.sv
// testbench of the timer bank: directed and random items checked against a timer model
module tb;

  localparam int LIMIT     = 2_000_000;
  localparam int LONG_HOLD = 3000;
  localparam logic [mtbdc_pkg::OP_W-1:0] OP_UNDEF = 2'd3;

  typedef struct packed {
    logic [mtbdc_pkg::ID_W-1:0]  id;
    logic [mtbdc_pkg::CNT_W-1:0] cnt;
    logic                        last;
  } expiry_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [mtbdc_pkg::IN_DW-1:0]    in_tdata = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [mtbdc_pkg::OUT_DW-1:0]   out_tdata;
  logic                           out_tlast;

  logic [mtbdc_pkg::TICK_W-1:0]  t_rem [8];
  logic [mtbdc_pkg::TICK_W-1:0]  t_per [8];
  logic [mtbdc_pkg::DRIFT_W-1:0] t_drift [8];
  expiry_t            expiry_q [$];
  int                 errors = 0;
  int                 cycles = 0;
  int                 send_idle = 0;
  int                 recv_idle = 0;
  int                 hold_cycles = 0;
  logic               hold_go = 1'b0;
  logic               hold_taken = 1'b0;

  multi_timer_bank_drift_comp_unit i_dut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL multi_timer_bank_drift_comp_unit");
      $finish;
    end
  end

  // predicts the expiries that one item causes
  task automatic predict_timers(input logic [1:0] op, input logic [2:0] id,
                                input logic [31:0] ms, input logic [15:0] el);
    logic [31:0] t;
    logic [31:0] over;
    logic [31:0] cnt;
    int          first_new;
    first_new = expiry_q.size();
    if (op == mtbdc_pkg::OP_START) begin
      t = (ms > mtbdc_pkg::TIME_CAP_IN) ? 32'hffff : ms;
      t = (t >= 100) ? t / 50 : 32'd1;
      t_rem[id] = t[15:0];
      t_per[id] = t[15:0];
      if (t > 1 && t_drift[id] >= 50) begin
        t_rem[id] = t_rem[id] - 1;
        t_drift[id] = t_drift[id] - 50;
      end
    end else if (op == mtbdc_pkg::OP_STOP) begin
      t_rem[id] = '0;
      t_per[id] = '0;
    end else if (op == mtbdc_pkg::OP_TICK) begin
      for (int i = 0; i < 8; i++) begin
        if (t_rem[i] != 0) begin
          if (t_rem[i] <= el) begin
            over = el - t_rem[i];
            cnt = 1;
            if (t_drift[i] >= 50) begin
              over = over + 1;
              t_drift[i] = t_drift[i] - 50;
            end
            if (t_per[i] != 0 && over >= t_per[i]) begin
              cnt = cnt + over / t_per[i];
              t_drift[i] = t_drift[i] + (over % t_per[i]) * 50;
            end
            t_rem[i] = '0;
            t_per[i] = '0;
            expiry_q.push_back('{id: i[2:0], cnt: cnt[16:0], last: 1'b0});
          end else begin
            t_rem[i] = t_rem[i] - el;
          end
        end
      end
      if (expiry_q.size() > first_new) expiry_q[expiry_q.size()-1].last = 1'b1;
    end
  endtask

  task automatic send_item(input logic [1:0] op, input logic [2:0] id,
                           input logic [31:0] ms, input logic [15:0] el);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    predict_timers(op, id, ms, el);
    in_tdata <= {3'd0, el, ms, id, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (expiry_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  // receiver side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (hold_go && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_cycles <= LONG_HOLD;
        out_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
      end
      if (out_tvalid && out_tready) begin
        if (expiry_q.size() == 0) begin
          $display("%0t unexpected expiry id %0d cnt %0d", $time,
                   out_tdata[2:0], out_tdata[19:3]);
          errors++;
        end else begin
          if (out_tdata[2:0] != expiry_q[0].id || out_tdata[19:3] != expiry_q[0].cnt
              || out_tlast != expiry_q[0].last) begin
            $display("%0t mismatch exp id %0d cnt %0d last %0b got id %0d cnt %0d last %0b",
                     $time, expiry_q[0].id, expiry_q[0].cnt, expiry_q[0].last,
                     out_tdata[2:0], out_tdata[19:3], out_tlast);
            errors++;
          end
          void'(expiry_q.pop_front());
        end
      end
    end
  end

  task automatic test_directed;
    send_item(mtbdc_pkg::OP_START, 3'd0, 32'd0, 16'd0);
    send_item(mtbdc_pkg::OP_START, 3'd1, 32'd99, 16'd0);
    send_item(mtbdc_pkg::OP_START, 3'd2, 32'd100, 16'd0);
    send_item(mtbdc_pkg::OP_START, 3'd3, 32'h0012_FFED, 16'd0);
    send_item(mtbdc_pkg::OP_START, 3'd4, 32'h0012_FFEE, 16'd0);
    send_item(mtbdc_pkg::OP_START, 3'd5, 32'hffff_ffff, 16'd0);
    send_item(mtbdc_pkg::OP_START, 3'd6, 32'd175, 16'd0);
    send_item(mtbdc_pkg::OP_START, 3'd7, 32'd1000, 16'd0);
    send_item(OP_UNDEF, 3'd7, 32'hffff_ffff, 16'hffff);
    send_item(mtbdc_pkg::OP_STOP, 3'd5, 32'd0, 16'd0);
    send_item(mtbdc_pkg::OP_TICK, 3'd0, 32'd0, 16'd0);
    send_item(mtbdc_pkg::OP_TICK, 3'd0, 32'd0, 16'd1);
    send_item(mtbdc_pkg::OP_TICK, 3'd0, 32'd0, 16'd30);
    send_item(mtbdc_pkg::OP_TICK, 3'd0, 32'd0, 16'hffff);
    send_item(mtbdc_pkg::OP_START, 3'd2, 32'd500, 16'd0);
    send_item(mtbdc_pkg::OP_START, 3'd6, 32'd50, 16'd0);
    send_item(mtbdc_pkg::OP_TICK, 3'd0, 32'd0, 16'd9);
    send_item(mtbdc_pkg::OP_TICK, 3'd0, 32'd0, 16'd5);
    send_item(mtbdc_pkg::OP_START, 3'd1, 32'hffff_ffff, 16'd0);
    send_item(mtbdc_pkg::OP_TICK, 3'd0, 32'd0, 16'hffff);
    drain();
  endtask

  task automatic test_random(input int n);
    logic [1:0] op;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: op = mtbdc_pkg::OP_START;
        4:          op = mtbdc_pkg::OP_STOP;
        5:          op = OP_UNDEF;
        default:    op = mtbdc_pkg::OP_TICK;
      endcase
      send_item(op, 3'($urandom_range(7)),
                ($urandom_range(7) == 0) ? $urandom : $urandom_range(5000),
                16'(($urandom_range(7) == 0) ? $urandom_range(16'hffff)
                                             : $urandom_range(120)));
    end
    drain();
  endtask

  task automatic test_backpressure;
    hold_go = 1'b1;
    for (int k = 0; k < 24; k++)
      send_item((k % 3 == 2) ? mtbdc_pkg::OP_TICK : mtbdc_pkg::OP_START, k[2:0],
                $urandom_range(400), 16'd20);
    drain();
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      t_rem[i] = '0;
      t_per[i] = '0;
      t_drift[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle = 10;
    recv_idle = 68;
    test_random(130);
    send_idle = 68;
    recv_idle = 10;
    test_random(130);
    send_idle = 0;
    recv_idle = 0;
    test_random(130);
    test_backpressure();
    if (errors == 0) begin
      $display("PASS multi_timer_bank_drift_comp_unit");
    end else begin
      $display("FAIL multi_timer_bank_drift_comp_unit");
    end
    $finish;
  end
endmodule
